>>> rtl/core/vwvc_pkg.sv
// ----------------------------------------------------------------------------
// vwvc_pkg
// shared types and constants of the voronoi wall voxel classifier
// ----------------------------------------------------------------------------
`default_nettype none
package vwvc_pkg;
    localparam int NODES_MAX = 64;
    localparam int NODE_W    = $clog2(NODES_MAX);
    localparam int CNT_W     = NODE_W + 1;
    localparam int COORD_W   = 8;
    localparam int FRAC_BITS = 8;
    // squared distance: three squares of 8-bit differences
    localparam int DIST_W    = 2 * COORD_W + 2;
    // radicand is distance shifted by two fraction fields
    localparam int RAD_W     = DIST_W + 2 * FRAC_BITS;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int SUM_W     = NODE_W + 1;

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    localparam logic [1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [1:0] REG_HOLE_LOW   = 2'd1;
    localparam logic [1:0] REG_HOLE_HIGH  = 2'd2;
    localparam logic [1:0] REG_ROAD_THR   = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [5:0]        node_index;
        logic [7:0]        coord_x;
        logic [7:0]        coord_y;
        logic [7:0]        coord_z;
    } t_in_item;

    typedef struct packed {
        logic              occupied;
        logic              on_boundary;
        logic              hole_wall;
        logic [5:0]        nearest_node;
        logic [5:0]        second_node;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0]  node_count;
        logic [7:0]        hole_sum_low;
        logic [7:0]        hole_sum_high;
        logic [15:0]       road_threshold;
    } t_cfg;

    // queue entry from front to back
    typedef struct packed {
        logic              cmd;
        logic [NODE_W-1:0] slot;
        logic [7:0]        x;
        logic [7:0]        y;
        logic [7:0]        z;
    } t_job;
endpackage
`default_nettype wire

>>> rtl/core/voronoi_wall_voxel_classifier_top.sv
// ----------------------------------------------------------------------------
// voronoi_wall_voxel_classifier_top
// seed loading and voronoi wall classification of voxels
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_stall with i_item; cmd 0 loads a seed into
//   slot node_index, cmd 1 classifies the voxel at (x, y, z)
//   output channel: o_valid / i_stall with o_item, one item per classify,
//   none per load
//   config: i_cfg_valid / o_cfg_ready, index 0..3 (node count, hole bounds,
//   road threshold); write only while idle; other indices are ignored
//   flow: a load is written into the seed table as the back end takes it; a
//   classify steps through each seed in the scan (read, square, add,
//   compare), then runs up to three roots (start, 17 result bits, done) on
//   the shared bit-per-cycle root unit; the scan and the root unit set the
//   time from accept to a valid result
//   a two-entry queue lets the front accept items while the back works
//   reset: config returns to 10 / 5 / 15 / 171; the seed table is not
//   cleared and must be written before it is used
//   stall: a held result keeps the back end waiting; the queue then fills
//   and o_stall rises
// ----------------------------------------------------------------------------
`default_nettype none
module voronoi_wall_voxel_classifier_top (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire vwvc_pkg::t_in_item   i_item,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output vwvc_pkg::t_out_item       o_item,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [15:0]          i_cfg_data
);
    import vwvc_pkg::*;

    t_cfg r_cfg;
    logic w_job_valid;
    logic w_job_take;
    t_job w_job;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_count     <= CNT_W'(10);
            r_cfg.hole_sum_low   <= 8'd5;
            r_cfg.hole_sum_high  <= 8'd15;
            r_cfg.road_threshold <= 16'd171;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_NODE_COUNT: r_cfg.node_count     <= i_cfg_data[CNT_W-1:0];
                REG_HOLE_LOW:   r_cfg.hole_sum_low   <= i_cfg_data[7:0];
                REG_HOLE_HIGH:  r_cfg.hole_sum_high  <= i_cfg_data[7:0];
                REG_ROAD_THR:   r_cfg.road_threshold <= i_cfg_data;
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    // front: accept and queue
    vwvc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_job_valid (w_job_valid),
        .i_job_take  (w_job_take),
        .o_job       (w_job)
    );

    // back: table, scan, roots, decision
    vwvc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (w_job_valid),
        .o_job_take  (w_job_take),
        .i_job       (w_job),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item)
    );
endmodule
`default_nettype wire

>>> rtl/core/vwvc_front.sv
// ----------------------------------------------------------------------------
// vwvc_front
// accepts items and pushes jobs into a two-entry queue
// ----------------------------------------------------------------------------
`default_nettype none
module vwvc_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire vwvc_pkg::t_in_item i_item,
    output logic                    o_job_valid,
    input  wire logic               i_job_take,
    output vwvc_pkg::t_job          o_job
);
    import vwvc_pkg::*;

    t_job       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;
    t_job       w_job;

    // slot and coordinate ranges match field widths here, so no screening needed
    assign w_job.cmd  = i_item.cmd;
    assign w_job.slot = i_item.node_index[NODE_W-1:0];
    assign w_job.x    = i_item.coord_x;
    assign w_job.y    = i_item.coord_y;
    assign w_job.z    = i_item.coord_z;

    assign o_stall     = (r_cnt == 2'd2);
    assign w_push      = i_valid && !o_stall;
    assign o_job_valid = (r_cnt != 2'd0);
    assign w_pop       = o_job_valid && i_job_take;
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_job;
                r_wp      <= ~r_wp;
            end
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !w_push) else $error("queue overflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> r_cnt != 2'd0) else $error("pop from empty queue");
endmodule
`default_nettype wire

>>> rtl/core/vwvc_sqrt.sv
// ----------------------------------------------------------------------------
// vwvc_sqrt
// iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module vwvc_sqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [vwvc_pkg::DIST_W-1:0] i_dist,
    output logic                             o_done,
    output logic [vwvc_pkg::ROOT_W-1:0]      o_root
);
    import vwvc_pkg::*;

    localparam int STEP_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  r_rem;
    logic [RAD_W-1:0]  r_val;
    logic [ROOT_W-1:0] r_root;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic [RAD_W+1:0]  w_rem2;
    logic [RAD_W+1:0]  w_trial;

    // shift in the next two radicand bits, try subtracting 4r+1
    assign w_rem2  = {r_rem, r_val[RAD_W-1 -: 2]};
    assign w_trial = {{(RAD_W-ROOT_W){1'b0}}, r_root, 2'b01};
    assign o_root  = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_step <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_root <= '0;
                r_val  <= {i_dist, {(2*FRAC_BITS){1'b0}}};
                r_step <= STEP_W'(ROOT_W);
            end else if (r_busy) begin
                r_val <= r_val << 2;
                if (w_rem2 >= w_trial) begin
                    r_rem  <= RAD_W'(w_rem2 - w_trial);
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_rem2[RAD_W-1:0];
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy)) else $error("root done without work");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_step > STEP_W'(1) |=> r_busy || $past(i_start))
        else $error("root unit dropped work");
    a_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_step == '0) else $error("step count left over");
endmodule
`default_nettype wire

>>> rtl/core/vwvc_back.sv
// ----------------------------------------------------------------------------
// vwvc_back
// seed table, nearest-pair scan, up to three roots and wall decision
// ----------------------------------------------------------------------------
`default_nettype none
module vwvc_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire vwvc_pkg::t_cfg       i_cfg,
    input  wire logic                 i_job_valid,
    output logic                      o_job_take,
    input  wire vwvc_pkg::t_job       i_job,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output vwvc_pkg::t_out_item       o_item
);
    import vwvc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_SQ, S_SUM, S_CMP, S_PAIR_RD, S_PAIR_SQ, S_PAIR_SUM,
        S_R1, S_R2, S_R12, S_DEC, S_OUT
    } t_state;

    t_state            r_state;
    logic [23:0]       r_mem [NODES_MAX];
    logic [23:0]       r_rd;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_i;
    logic [NODE_W-1:0] r_idx;
    logic [NODE_W-1:0] r_first;
    logic [NODE_W-1:0] r_second;
    logic              r_have1;
    logic              r_have2;
    logic [DIST_W-1:0] r_d1;
    logic [DIST_W-1:0] r_d2;
    logic [DIST_W-1:0] r_d;
    logic [2*COORD_W-1:0] r_sx;
    logic [2*COORD_W-1:0] r_sy;
    logic [2*COORD_W-1:0] r_sz;
    logic [ROOT_W-1:0] r_r1;
    logic [ROOT_W-1:0] r_r2;
    logic              r_sq_start;
    logic [DIST_W-1:0] r_sq_in;
    logic              w_sq_done;
    logic [ROOT_W-1:0] w_sq_root;
    logic [7:0]        r_ax;
    logic [7:0]        r_ay;
    logic [7:0]        r_az;
    logic              r_wall;
    logic              r_holed;
    logic              r_occ;
    logic [7:0]        w_dx;
    logic [7:0]        w_dy;
    logic [7:0]        w_dz;
    logic [SUM_W-1:0]  w_sum;
    logic [ROOT_W:0]   w_rsum;
    logic [ROOT_W+1:0] w_gap_ok_lhs;

    vwvc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_start),
        .i_dist  (r_sq_in),
        .o_done  (w_sq_done),
        .o_root  (w_sq_root)
    );

    // absolute axis differences against the value read from the table
    assign w_dx = (r_ax > r_rd[23:16]) ? r_ax - r_rd[23:16] : r_rd[23:16] - r_ax;
    assign w_dy = (r_ay > r_rd[15:8])  ? r_ay - r_rd[15:8]  : r_rd[15:8]  - r_ay;
    assign w_dz = (r_az > r_rd[7:0])   ? r_az - r_rd[7:0]   : r_rd[7:0]   - r_az;
    assign w_sum  = {1'b0, r_first} + {1'b0, r_second};
    assign w_rsum = {1'b0, r_r1} + {1'b0, r_r2};
    // gap >= thr  <=>  r1 + r2 >= r12 + thr
    assign w_gap_ok_lhs = {1'b0, w_rsum};

    assign o_job_take = (r_state == S_IDLE) && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (o_job_take && i_job.cmd == CMD_LOAD)
            r_mem[i_job.slot] <= {i_job.x, i_job.y, i_job.z};
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            o_valid    <= 1'b0;
            r_sq_start <= 1'b0;
        end else begin
            r_sq_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_job_take && i_job.cmd == CMD_CLASSIFY) begin
                        r_ax    <= i_job.x;
                        r_ay    <= i_job.y;
                        r_az    <= i_job.z;
                        r_n     <= (i_cfg.node_count > CNT_W'(NODES_MAX))
                                   ? CNT_W'(NODES_MAX) : i_cfg.node_count;
                        r_i     <= '0;
                        r_idx   <= '0;
                        r_have1 <= 1'b0;
                        r_have2 <= 1'b0;
                        r_first <= '0;
                        r_second <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    // table read lands in r_rd next cycle
                    if (r_i >= r_n) r_state <= S_R1;
                    else r_state <= S_SQ;
                end
                S_SQ: begin
                    r_sx    <= w_dx * w_dx;
                    r_sy    <= w_dy * w_dy;
                    r_sz    <= w_dz * w_dz;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_d     <= DIST_W'(r_sx) + DIST_W'(r_sy) + DIST_W'(r_sz);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (!r_have1 || r_d < r_d1) begin
                        if (r_have1) begin
                            r_d2     <= r_d1;
                            r_second <= r_first;
                            r_have2  <= 1'b1;
                        end
                        r_d1    <= r_d;
                        r_first <= r_i[NODE_W-1:0];
                        r_have1 <= 1'b1;
                    end else if (!r_have2 || r_d < r_d2) begin
                        r_d2     <= r_d;
                        r_second <= r_i[NODE_W-1:0];
                        r_have2  <= 1'b1;
                    end
                    r_i     <= r_i + 1'b1;
                    r_idx   <= NODE_W'(r_i + 1'b1);
                    r_state <= S_RD;
                end
                S_R1: begin
                    if (!r_have2) begin
                        r_occ    <= 1'b0;
                        r_wall   <= 1'b0;
                        r_holed  <= 1'b0;
                        r_second <= '0;
                        if (!r_have1) r_first <= '0;
                        o_valid  <= 1'b1;
                        r_state  <= S_OUT;
                    end else begin
                        r_sq_in    <= r_d1;
                        r_sq_start <= 1'b1;
                        r_idx      <= r_first;
                        r_state    <= S_R2;
                    end
                end
                S_R2: begin
                    if (w_sq_done) begin
                        r_r1       <= w_sq_root;
                        r_sq_in    <= r_d2;
                        r_sq_start <= 1'b1;
                        r_state    <= S_PAIR_RD;
                    end
                end
                S_PAIR_RD: begin
                    // r_rd holds seed first; measure to seed second
                    if (w_sq_done) begin
                        r_r2    <= w_sq_root;
                        r_ax    <= r_rd[23:16];
                        r_ay    <= r_rd[15:8];
                        r_az    <= r_rd[7:0];
                        r_idx   <= r_second;
                        r_holed <= ({1'b0, w_sum} > i_cfg.hole_sum_low) &&
                                   ({1'b0, w_sum} < i_cfg.hole_sum_high);
                        r_state <= S_PAIR_SQ;
                    end
                end
                S_PAIR_SQ: begin
                    r_wall  <= (r_r2 - r_r1) < ROOT_W'(1 << FRAC_BITS);
                    r_state <= S_PAIR_SUM;
                end
                S_PAIR_SUM: begin
                    r_sx    <= w_dx * w_dx;
                    r_sy    <= w_dy * w_dy;
                    r_sz    <= w_dz * w_dz;
                    r_state <= S_R12;
                end
                S_R12: begin
                    if (!r_wall) begin
                        r_occ   <= 1'b0;
                        o_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else if (!r_holed) begin
                        r_occ   <= 1'b1;
                        o_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_sq_in    <= DIST_W'(r_sx) + DIST_W'(r_sy) + DIST_W'(r_sz);
                        r_sq_start <= 1'b1;
                        r_state    <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (w_sq_done) begin
                        r_occ   <= w_gap_ok_lhs >=
                                   ({2'b00, w_sq_root} + (ROOT_W+2)'(i_cfg.road_threshold));
                        o_valid <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_item.occupied     = r_occ;
    assign o_item.on_boundary  = r_wall;
    assign o_item.hole_wall    = r_holed;
    assign o_item.nearest_node = r_first;
    assign o_item.second_node  = r_second;

    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_OUT) else $error("result outside output state");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item)) else $error("result lost");
    a_occ_wall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.occupied |-> o_item.on_boundary) else $error("occupied off wall");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_take |-> !o_valid) else $error("job taken while result pending");
endmodule
`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the voronoi wall voxel classifier
// ----------------------------------------------------------------------------
// seeds are loaded and voxels classified through the item channel while a
// scoreboard class works out the expected wall, hole and occupancy flags
// from its own copy of the seed table and registers. Each result item is
// compared field by field with the oldest expected one. Registers are
// rewritten between phases once the block has drained. Both sides idle and
// stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

import vwvc_pkg::*;

class vox_scoreboard;
    logic [7:0]  seed_x [NODES_MAX];
    logic [7:0]  seed_y [NODES_MAX];
    logic [7:0]  seed_z [NODES_MAX];
    logic [6:0]  node_count = 7'd10;
    logic [7:0]  hole_low   = 8'd5;
    logic [7:0]  hole_high  = 8'd15;
    logic [15:0] road_thr   = 16'd171;
    t_out_item   awaited [$];
    int          errors, classified, walls, occupied;

    // bit-by-bit integer square root
    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned span_sq(int ax, int ay, int az, int s);
        int dx, dy, dz;
        dx = ax - int'(seed_x[s]);
        dy = ay - int'(seed_y[s]);
        dz = az - int'(seed_z[s]);
        return longint'(dx * dx + dy * dy + dz * dz);
    endfunction

    function automatic longint unsigned q8_root(longint unsigned d);
        return isqrt(d << (2 * FRAC_BITS));
    endfunction

    function void note_input(t_in_item it);
        int n, first, second;
        bit have1, have2;
        longint unsigned d, d1, d2, r1, r2, r12;
        longint gap;
        int sum;
        t_out_item res;
        if (it.cmd == CMD_LOAD) begin
            seed_x[it.node_index] = it.coord_x;
            seed_y[it.node_index] = it.coord_y;
            seed_z[it.node_index] = it.coord_z;
            return;
        end
        n = (node_count > NODES_MAX) ? NODES_MAX : node_count;
        first = 0; second = 0; have1 = 0; have2 = 0; d1 = 0; d2 = 0;
        for (int i = 0; i < n; i++) begin
            d = span_sq(it.coord_x, it.coord_y, it.coord_z, i);
            if (!have1 || d < d1) begin
                if (have1) begin
                    d2 = d1; second = first; have2 = 1;
                end
                d1 = d; first = i; have1 = 1;
            end else if (!have2 || d < d2) begin
                d2 = d; second = i; have2 = 1;
            end
        end
        res = '0;
        if (have2) begin
            r1 = q8_root(d1);
            r2 = q8_root(d2);
            sum = first + second;
            res.on_boundary = (r2 - r1) < (64'd1 << FRAC_BITS);
            res.hole_wall = (sum > hole_low) && (sum < hole_high);
            if (res.on_boundary) begin
                if (res.hole_wall) begin
                    r12 = q8_root(span_sq(seed_x[first], seed_y[first],
                                          seed_z[first], second));
                    gap = longint'(r1 + r2) - longint'(r12);
                    res.occupied = gap >= longint'(road_thr);
                end else begin
                    res.occupied = 1;
                end
            end
        end else begin
            second = 0;
        end
        res.nearest_node = first[5:0];
        res.second_node  = second[5:0];
        awaited.insert(awaited.size(), res);
        classified++;
        walls += res.on_boundary;
        occupied += res.occupied;
    endfunction

    function void check_result(t_out_item got);
        t_out_item exp_item;
        if (awaited.size() == 0) begin
            $error("unexpected result item %p", got);
            errors++;
            return;
        end
        exp_item = awaited.pop_front();
        if (got.occupied !== exp_item.occupied) begin
            $error("occupied: expected %0d, got %0d", exp_item.occupied, got.occupied);
            errors++;
        end
        if (got.on_boundary !== exp_item.on_boundary) begin
            $error("on_boundary: expected %0d, got %0d",
                   exp_item.on_boundary, got.on_boundary);
            errors++;
        end
        if (got.hole_wall !== exp_item.hole_wall) begin
            $error("hole_wall: expected %0d, got %0d", exp_item.hole_wall, got.hole_wall);
            errors++;
        end
        if (got.nearest_node !== exp_item.nearest_node) begin
            $error("nearest_node: expected %0d, got %0d",
                   exp_item.nearest_node, got.nearest_node);
            errors++;
        end
        if (got.second_node !== exp_item.second_node) begin
            $error("second_node: expected %0d, got %0d",
                   exp_item.second_node, got.second_node);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int STALL_LIMIT = 5000;   // cycles with no handshake at all
    localparam int SETTLE      = 400;    // longest classify plus margin

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    t_in_item    i_item = '0;
    logic        o_valid;
    logic        i_stall = 0;
    t_out_item   o_item;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    vox_scoreboard voxels = new();
    bit quiet = 0;          // no idling and no stalls while set
    int no_accept = 0;
    int sent = 0;

    voronoi_wall_voxel_classifier_top dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver stalls at random, except in the quiet stretch
    always @(posedge i_clk) begin
        i_stall <= quiet ? 1'b0 : ($urandom_range(99) < 35);
    end

    // result monitor, sampled at the edge before any update
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) voxels.check_result(o_item);
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            no_accept <= 0;
        end else if (no_accept >= STALL_LIMIT) begin
            $display("voronoi_wall_voxel_classifier_top regression: fail");
            $finish;
        end else begin
            no_accept <= no_accept + 1;
        end
    end

    // one item, with random idle cycles in front; valid stays high after
    task automatic send_item(t_in_item it);
        while (!quiet && $urandom_range(99) < 35) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        voxels.note_input(it);
        sent++;
    endtask

    task automatic load_seed(int slot, int x, int y, int z);
        t_in_item it;
        it = '{cmd: CMD_LOAD, node_index: slot[5:0], coord_x: x[7:0],
               coord_y: y[7:0], coord_z: z[7:0]};
        send_item(it);
    endtask

    task automatic classify(int x, int y, int z);
        t_in_item it;
        it = '{cmd: CMD_CLASSIFY, node_index: 6'($urandom), coord_x: x[7:0],
               coord_y: y[7:0], coord_z: z[7:0]};
        send_item(it);
    endtask

    // sender holds off until every expected item is back, then lets the
    // block finish any load still in flight
    task automatic drain();
        i_valid <= 1'b0;
        wait (voxels.awaited.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[15:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_NODE_COUNT: voxels.node_count = value[6:0];
            REG_HOLE_LOW:   voxels.hole_low   = value[7:0];
            REG_HOLE_HIGH:  voxels.hole_high  = value[7:0];
            REG_ROAD_THR:   voxels.road_thr   = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(int n, int lo, int hi, int thr);
        drain();
        write_reg(REG_NODE_COUNT, n);
        write_reg(REG_HOLE_LOW, lo);
        write_reg(REG_HOLE_HIGH, hi);
        write_reg(REG_ROAD_THR, thr);
    endtask

    // voxel near the midpoint of two seeds, so walls are hit often
    task automatic classify_between(int n);
        int a, b, j;
        a = $urandom_range(n - 1);
        b = $urandom_range(n - 1);
        j = $urandom_range(2);
        classify(((voxels.seed_x[a] + voxels.seed_x[b]) >> 1) + $urandom_range(2 * j) - j,
                 ((voxels.seed_y[a] + voxels.seed_y[b]) >> 1) + $urandom_range(2 * j) - j,
                 ((voxels.seed_z[a] + voxels.seed_z[b]) >> 1) + $urandom_range(2 * j) - j);
    endtask

    task automatic random_phase(int n, int items);
        int roll;
        for (int k = 0; k < items; k++) begin
            quiet = (sent >= 200 && sent < 280);
            roll = $urandom_range(99);
            if (roll < 15) begin
                load_seed($urandom_range(63), $urandom_range(255),
                          $urandom_range(255), $urandom_range(255));
            end else if (roll < 70) begin
                classify_between(n);
            end else begin
                classify($urandom_range(255), $urandom_range(255), $urandom_range(255));
            end
        end
    endtask

    initial begin
        int n;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part under the reset registers: ten seeds, extremes
        load_seed(0, 0, 0, 0);
        load_seed(1, 255, 255, 255);
        load_seed(2, 10, 0, 0);
        load_seed(3, 0, 10, 0);
        for (int s = 4; s < 10; s++) load_seed(s, 40 * s - 100, 200 - 20 * s, 128);
        load_seed(63, 255, 0, 170);
        classify(0, 0, 0);           // voxel on a seed
        classify(255, 255, 255);
        classify(5, 0, 0);           // tie between seeds 0 and 2
        classify(5, 5, 0);           // three-way tie, lower index wins
        classify(128, 128, 128);
        classify(85, 170, 85);

        // a single seed: nothing can be occupied
        set_regs(1, 5, 15, 171);
        classify(5, 0, 0);
        classify(200, 17, 99);
        // any sum holed, unreachable and zero thresholds
        set_regs(4, 0, 128, 65535);
        classify(5, 0, 0);
        classify(5, 5, 0);
        set_regs(4, 0, 128, 0);
        classify(5, 0, 0);
        classify(5, 5, 0);

        // fill the whole table before the random part
        for (int s = 0; s < NODES_MAX; s++) begin
            if ($urandom_range(1)) load_seed(s, $urandom_range(255),
                                             $urandom_range(255), $urandom_range(255));
            else load_seed(s, 100 + $urandom_range(40), 100 + $urandom_range(40),
                           100 + $urandom_range(40));
        end

        set_regs(64, 0, 128, 0);       random_phase(64, 60);
        set_regs(2, 5, 15, 171);       random_phase(2, 50);
        set_regs(33, 20, 50, 300);     random_phase(33, 60);
        set_regs(64, 128, 0, 65535);   random_phase(64, 50);
        set_regs(1, 0, 128, 0);        random_phase(1, 20);
        set_regs(12, 3, 19, 171);      random_phase(12, 60);
        n = $urandom_range(2, 64);
        set_regs(n, $urandom_range(128), $urandom_range(128), $urandom_range(1023));
        random_phase(n, 60);

        quiet = 0;
        drain();
        $display("covered %0d items, %0d voxels classified, %0d on walls, %0d occupied",
                 sent, voxels.classified, voxels.walls, voxels.occupied);
        if (voxels.errors == 0 && voxels.awaited.size() == 0) begin
            $display("voronoi_wall_voxel_classifier_top regression: pass");
        end else begin
            $display("voronoi_wall_voxel_classifier_top regression: fail");
        end
        $finish;
    end
endmodule

`default_nettype wire

>>> voronoi_wall_voxel_classifier_top.f
rtl/core/vwvc_pkg.sv
rtl/core/vwvc_front.sv
rtl/core/vwvc_sqrt.sv
rtl/core/vwvc_back.sv
rtl/core/voronoi_wall_voxel_classifier_top.sv
bench/tb_top.sv
